// ===== design/spe_pkg.sv =====
// Package: shared types and constants for the parity extract stream unit.
`timescale 1ns / 1ps
package spe_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned POS_W  = 3;
  localparam int unsigned LEN_W  = 16;
  localparam logic [POS_W-1:0] LAST_POS = 3'd7;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_LEN_HI = 2'd1,
    PH_LEN_LO = 2'd2,
    PH_DATA   = 2'd3
  } phase_t;

  // one registered pixel reduced to what the extractor needs
  typedef struct packed {
    logic start;
    logic bit_val;
  } pix_t;

endpackage

// ===== design/spe_ifs.sv =====
// Interfaces: pixel request channel and message byte channel.
`timescale 1ns / 1ps
interface spe_pixel_if;
  logic       valid;
  logic       ready;
  logic       frame_start;
  logic [7:0] green_value;
  logic [7:0] blue_value;

  modport source (output valid, output frame_start, output green_value,
                  output blue_value, input ready);
  modport sink   (input valid, input frame_start, input green_value,
                  input blue_value, output ready);
endinterface

interface spe_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] message_byte;
  logic       last_byte;

  modport source (output valid, output message_byte, output last_byte, input ready);
  modport sink   (input valid, input message_byte, input last_byte, output ready);
endinterface

// ===== design/spe_in_reg.sv =====
// Input register: captures a pixel request and reduces it to start flag and parity bit.
`timescale 1ns / 1ps
module spe_in_reg (
  input  logic          clk,
  input  logic          rst,
  spe_pixel_if.sink     pixel_in,
  output logic          pix_valid,
  output spe_pkg::pix_t pix,
  input  logic          pix_take
);
  import spe_pkg::*;

  logic pix_valid_next;

  assign pixel_in.ready = !pix_valid || pix_take;
  assign pix_valid_next = pixel_in.valid || (pix_valid && !pix_take);

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else begin
      pix_valid <= pix_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pixel_in.valid && pixel_in.ready) begin
      pix.start   <= pixel_in.frame_start;
      pix.bit_val <= pixel_in.green_value[0] ^ pixel_in.blue_value[0];
    end
  end

endmodule

// ===== design/spe_core.sv =====
// Extraction core: bit packing, length header, byte countdown and result register.
`timescale 1ns / 1ps
module spe_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          pix_valid,
  input  spe_pkg::pix_t pix,
  output logic          pix_take,
  spe_byte_if.source    byte_out
);
  import spe_pkg::*;

  phase_t            phase, phase_next, ph_eff;
  logic [POS_W-1:0]  bit_position, bit_position_next, pos_eff;
  logic [BYTE_W-1:0] byte_accumulator, byte_accumulator_next, acc_eff, acc_new;
  logic [BYTE_W-1:0] length_high, length_high_next;
  logic [LEN_W-1:0]  bytes_remaining, bytes_remaining_next, len_new;
  logic              emit, emit_last;

  logic              res_valid;
  logic [BYTE_W-1:0] res_byte;
  logic              res_last;

  assign pix_take = pix_valid && (!res_valid || byte_out.ready);

  always_comb begin
    ph_eff   = pix.start ? PH_LEN_HI : phase;
    pos_eff  = pix.start ? '0 : bit_position;
    acc_eff  = pix.start ? '0 : byte_accumulator;
    acc_new  = acc_eff | (BYTE_W'(pix.bit_val) << pos_eff);
    len_new  = {length_high, acc_new};

    phase_next            = ph_eff;
    bit_position_next     = pos_eff;
    byte_accumulator_next = acc_eff;
    length_high_next      = length_high;
    bytes_remaining_next  = bytes_remaining;
    emit                  = 1'b0;
    emit_last             = (bytes_remaining == LEN_W'(1));

    if (ph_eff != PH_IDLE) begin
      if (pos_eff != LAST_POS) begin
        bit_position_next     = pos_eff + POS_W'(1);
        byte_accumulator_next = acc_new;
      end else begin
        bit_position_next     = '0;
        byte_accumulator_next = '0;
        case (ph_eff)
          PH_LEN_HI: begin
            length_high_next = acc_new;
            phase_next       = PH_LEN_LO;
          end
          PH_LEN_LO: begin
            bytes_remaining_next = len_new;
            phase_next           = (len_new == '0) ? PH_IDLE : PH_DATA;
          end
          PH_DATA: begin
            bytes_remaining_next = bytes_remaining - LEN_W'(1);
            emit                 = 1'b1;
            if (emit_last) begin
              phase_next = PH_IDLE;
            end
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      bit_position     <= '0;
      byte_accumulator <= '0;
      length_high      <= '0;
      bytes_remaining  <= '0;
      res_valid        <= 1'b0;
    end else begin
      if (pix_take) begin
        phase            <= phase_next;
        bit_position     <= bit_position_next;
        byte_accumulator <= byte_accumulator_next;
        length_high      <= length_high_next;
        bytes_remaining  <= bytes_remaining_next;
        res_valid        <= emit;
      end else if (byte_out.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pix_take && emit) begin
      res_byte <= acc_new;
      res_last <= emit_last;
    end
  end

  assign byte_out.valid        = res_valid;
  assign byte_out.message_byte = res_byte;
  assign byte_out.last_byte    = res_last;

`ifndef SYNTHESIS
  a_idle_no_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_IDLE |-> bytes_remaining == '0)
    else $error("idle with bytes still counted");
  a_data_has_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DATA |-> bytes_remaining != '0)
    else $error("data phase with zero count");
  a_idle_aligned: assert property (@(posedge clk) disable iff (rst)
    phase == PH_IDLE |-> bit_position == '0)
    else $error("idle with partial byte");
  a_last_goes_idle: assert property (@(posedge clk) disable iff (rst)
    pix_take && emit && emit_last |=> phase == PH_IDLE && res_valid && res_last)
    else $error("last byte did not end message");
`endif

endmodule

// ===== design/stego_parity_extract_stream_unit.sv =====
// Top level: pixel parity hidden message extractor.
`timescale 1ns / 1ps
// Takes one pixel request per clock and recovers one hidden bit from it, the
// LSB of green XOR the LSB of blue, packed LSB first into bytes. After a frame
// start the first two bytes give a 16-bit length (high byte first), then that
// many message bytes come out, the final one flagged by last_byte; a zero
// length yields nothing. A pixel is registered on entry, then decoded and
// counted by the core, and a finished byte is loaded into the output register.
// A new pixel is taken every cycle as long as the output register drains;
// one pixel can be held while a result waits.
module stego_parity_extract_stream_unit (
  input  logic       clk,
  input  logic       rst,
  spe_pixel_if.sink  pixel_in,
  spe_byte_if.source byte_out
);
  import spe_pkg::*;

  logic pix_valid;
  pix_t pix;
  logic pix_take;

  spe_in_reg u_in_reg (
    .clk       (clk),
    .rst       (rst),
    .pixel_in  (pixel_in),
    .pix_valid (pix_valid),
    .pix       (pix),
    .pix_take  (pix_take)
  );

  spe_core u_core (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix       (pix),
    .pix_take  (pix_take),
    .byte_out  (byte_out)
  );

endmodule

// ===== dv/tb_stego_parity_extract_stream_unit.sv =====
// Testbench: directed and randomized pixel stream against a cycle-free predictor of the parity extractor.
`timescale 1ns / 1ps
module tb_stego_parity_extract_stream_unit;
  import spe_pkg::*;

  localparam int unsigned RAND_PIXELS = 1000;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned HOLD_AFTER  = 300;
  localparam int unsigned DRAIN_WAIT  = 12;

  typedef struct packed {
    logic       fs;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_req_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } msg_byte_t;

  logic clk;
  logic rst;

  spe_pixel_if pix_if ();
  spe_byte_if  byte_if ();

  stego_parity_extract_stream_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .pixel_in (pix_if),
    .byte_out (byte_if)
  );

  // predictor state
  phase_t           ex_phase;
  logic [POS_W-1:0] ex_pos;
  logic [7:0]       ex_acc;
  logic [7:0]       ex_len_hi;
  logic [LEN_W-1:0] ex_remaining;

  pixel_req_t pixel_q[$];
  msg_byte_t  msg_q[$];

  int unsigned err_cnt    = 0;
  int unsigned pix_sent   = 0;
  int unsigned bytes_seen = 0;
  int unsigned frames     = 0;
  int unsigned cycle      = 0;
  logic        pix_acc    = 1'b0;
  logic        drain      = 1'b0;

  // sender burst state
  int unsigned gap_left   = 0;
  int unsigned burst_left = 0;

  // receiver state
  int unsigned mode       = 0;
  int unsigned mode_left  = 0;
  int unsigned hold_left  = 0;
  logic        hold_done  = 1'b0;

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    pix_if.valid       = 1'b0;
    pix_if.frame_start = 1'b0;
    pix_if.green_value = '0;
    pix_if.blue_value  = '0;
    byte_if.ready      = 1'b0;
  end

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic parity_extract_step(input pixel_req_t p);
    logic       bit_v;
    logic [7:0] done;
    bit_v = p.green[0] ^ p.blue[0];
    if (p.fs) begin
      ex_phase = PH_LEN_HI;
      ex_pos   = '0;
      ex_acc   = '0;
    end
    if (ex_phase != PH_IDLE) begin
      ex_acc[ex_pos] = ex_acc[ex_pos] | bit_v;
      if (ex_pos != LAST_POS) begin
        ex_pos = ex_pos + POS_W'(1);
      end else begin
        done   = ex_acc;
        ex_pos = '0;
        ex_acc = '0;
        case (ex_phase)
          PH_LEN_HI: begin
            ex_len_hi = done;
            ex_phase  = PH_LEN_LO;
          end
          PH_LEN_LO: begin
            ex_remaining = {ex_len_hi, done};
            ex_phase     = (ex_remaining == '0) ? PH_IDLE : PH_DATA;
          end
          default: begin
            ex_remaining = ex_remaining - LEN_W'(1);
            msg_q.push_back('{data: done, last: (ex_remaining == '0)});
            if (ex_remaining == '0) ex_phase = PH_IDLE;
          end
        endcase
      end
    end
  endtask

  task automatic push_pixel(input logic fs, input logic bit_v);
    pixel_req_t p;
    p.fs       = fs;
    p.green    = 8'($urandom_range(0, 255));
    p.blue     = 8'($urandom_range(0, 255));
    p.blue[0]  = p.green[0] ^ bit_v;
    pixel_q.push_back(p);
  endtask

  task automatic push_byte(input logic [7:0] data, input logic first);
    for (int i = 0; i < 8; i++) push_pixel(first && (i == 0), data[i]);
  endtask

  // length header, then n_data bytes, then cut_bits stray pixels
  task automatic push_frame(input logic [15:0] len, input int unsigned n_data,
                            input int unsigned cut_bits);
    frames++;
    push_byte(len[15:8], 1'b1);
    push_byte(len[7:0], 1'b0);
    for (int unsigned i = 0; i < n_data; i++) push_byte(8'($urandom_range(0, 255)), 1'b0);
    for (int unsigned i = 0; i < cut_bits; i++) push_pixel(1'b0, 1'($urandom_range(0, 1)));
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) return 0;
    if (r < 9) return $urandom_range(1, 5);
    return $urandom_range(10, 20);
  endfunction

  // stimulus and end of run
  initial begin
    int unsigned base;
    int unsigned r;
    int unsigned len;
    ex_phase     = PH_IDLE;
    ex_pos       = '0;
    ex_acc       = '0;
    ex_len_hi    = '0;
    ex_remaining = '0;

    // ignored before any frame start, field extremes
    pixel_q.push_back('{fs: 1'b0, green: 8'h00, blue: 8'h00});
    pixel_q.push_back('{fs: 1'b0, green: 8'hff, blue: 8'hff});
    pixel_q.push_back('{fs: 1'b0, green: 8'hff, blue: 8'h00});
    pixel_q.push_back('{fs: 1'b0, green: 8'h00, blue: 8'hff});
    // zero length, trailing pixels ignored
    push_frame(16'h0000, 0, 3);
    // single byte message, then ignored pixels
    frames++;
    push_byte(8'h00, 1'b1);
    push_byte(8'h01, 1'b0);
    push_byte(8'ha5, 1'b0);
    push_pixel(1'b0, 1'b1);
    push_pixel(1'b0, 1'b1);
    // maximum length, abandoned by a frame start mid-byte
    frames++;
    push_byte(8'hff, 1'b1);
    push_byte(8'hff, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hff, 1'b0);
    push_pixel(1'b0, 1'b1);
    push_pixel(1'b0, 1'b0);
    push_pixel(1'b0, 1'b1);
    // restart inside the length header
    frames++;
    for (int i = 0; i < 5; i++) push_pixel(i == 0, 1'b1);
    frames++;
    push_byte(8'h00, 1'b1);
    push_byte(8'h02, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h01, 1'b0);

    base = pixel_q.size();
    while (pixel_q.size() < base + RAND_PIXELS) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
        push_frame(16'(len), len, $urandom_range(0, 3));
      end else if (r < 85) begin
        len = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 65535) : $urandom_range(2, 8);
        push_frame(16'(len), $urandom_range(0, 3), $urandom_range(0, 7));
      end else begin
        r = $urandom_range(1, 10);
        for (int unsigned i = 0; i < r; i++) begin
          push_pixel($urandom_range(0, 7) == 0, 1'($urandom_range(0, 1)));
        end
      end
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pixel_q.size() != 0 || msg_q.size() != 0) @(posedge clk);
    drain = 1'b1;
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("run covered %0d pixels in %0d frames, %0d message bytes checked",
             pix_sent, frames, bytes_seen);
    $display("sender bursts and gaps, receiver stalls incl. one %0d-cycle hold-off",
             HOLD_CYCLES);
    if (err_cnt == 0) begin
      $display("[stego_parity_extract_stream_unit] OK");
    end else begin
      $display("[stego_parity_extract_stream_unit] ERROR");
    end
    $finish;
  end

  // request acceptance and prediction
  always @(posedge clk) begin
    pix_acc = pix_if.valid && pix_if.ready;
    if (!rst && pix_acc) begin
      parity_extract_step(pixel_q[0]);
      pixel_q.pop_front();
      pix_sent++;
    end
  end

  // pixel driver
  always @(negedge clk) begin
    if (rst) begin
      pix_if.valid <= 1'b0;
    end else if (pix_if.valid && !pix_acc) begin
      // hold the pending request
    end else if (gap_left != 0) begin
      gap_left--;
      pix_if.valid <= 1'b0;
    end else if (pixel_q.size() != 0) begin
      pix_if.valid       <= 1'b1;
      pix_if.frame_start <= pixel_q[0].fs;
      pix_if.green_value <= pixel_q[0].green;
      pix_if.blue_value  <= pixel_q[0].blue;
      if (burst_left <= 1) begin
        burst_left = $urandom_range(1, 40);
        gap_left   = pick_gap();
      end else begin
        burst_left--;
      end
    end else begin
      pix_if.valid <= 1'b0;
    end
  end

  // receiver ready pattern
  always @(negedge clk) begin
    if (rst) begin
      byte_if.ready <= 1'b0;
    end else if (drain) begin
      byte_if.ready <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left--;
      byte_if.ready <= 1'b0;
    end else if (!hold_done && pix_sent >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      byte_if.ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 2);
        mode_left = $urandom_range(8, 80);
      end else begin
        mode_left--;
      end
      case (mode)
        0:       byte_if.ready <= 1'b1;
        1:       byte_if.ready <= ($urandom_range(0, 3) != 0);
        default: byte_if.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && byte_if.valid === 1'b1 && byte_if.ready === 1'b1) begin
      if (msg_q.size() == 0) begin
        $error("unexpected message byte %0h (last %0b)", byte_if.message_byte,
               byte_if.last_byte);
        err_cnt++;
      end else begin
        if (byte_if.message_byte !== msg_q[0].data) begin
          $error("message_byte: expected %0h, got %0h", msg_q[0].data, byte_if.message_byte);
          err_cnt++;
        end
        if (byte_if.last_byte !== msg_q[0].last) begin
          $error("last_byte: expected %0b, got %0b", msg_q[0].last, byte_if.last_byte);
          err_cnt++;
        end
        msg_q.pop_front();
        bytes_seen++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle++;
    if (cycle > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d requests pending", cycle, pixel_q.size());
      $display("[stego_parity_extract_stream_unit] ERROR");
      $finish;
    end
  end

endmodule
